>>> hw/rtl/plkt_pkg.sv
// ----------------------------------------------------------------------------
// plkt_pkg
// Shared types, codes and constants of the parent-linked key table.
// ----------------------------------------------------------------------------
package plkt_pkg;

  localparam int DEFAULT_SLOTS = 64;
  localparam int MAX_RESULTS   = 64;
  localparam int RES_BITS      = $clog2(MAX_RESULTS + 1);
  localparam logic [6:0] CAPACITY_RESET = 7'd64;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;
  localparam logic [1:0] CMD_LIST   = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOPARENT = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic       ld_req;
    logic       inc_idx;
    logic       clr_idx;
    logic       idx_last;
    logic       upd_flags;
    logic       cap_hit;
    logic       wr_add;
    logic       wr_move;
    logic       wr_clr;
    logic       cnt_dec;
    logic       out_load;
    logic [2:0] out_status;
    logic       out_found;
    logic       out_last;
  } plkt_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       scan_end;
    logic       key_hit;
    logic       par_hit;
    logic       par_is_key;
    logic       pend_v;
    logic       out_free;
    logic       nres_max;
    logic [2:0] add_stat;
  } plkt_stat_t;

endpackage

>>> hw/rtl/parent_linked_key_table_unit.sv
// ----------------------------------------------------------------------------
// parent_linked_key_table_unit
// Packed table of entries (key, parent key, data word) with add, delete,
// search and list-by-parent requests.
// ----------------------------------------------------------------------------
// Usage: a request enters on the in_valid/in_ready channel and is accepted
// only while the unit is idle. Each request produces one or more results on
// the out_valid/out_ready channel; the final result of a request has last set.
// Every request scans the stored entries through one memory read port, with a
// read state and an evaluate state for each entry. A delete that hits adds a
// move of the last entry and a second pass over the entries to clear orphaned
// parent links. A list request yields one result per matching entry, at most
// 64. A stalled receiver holds the output register and pauses the scan.
// The capacity register is written through cfg_we/cfg_wdata; the user must
// write it only while idle, as the unit does not enforce this.
// Reset empties the table and sets the capacity to 64; no clearing pass.
// ----------------------------------------------------------------------------
module parent_linked_key_table_unit import plkt_pkg::*; #(
  parameter int SLOTS = DEFAULT_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [31:0] key,
  input  logic [31:0] parent_key,
  input  logic [31:0] info,
  input  logic        check_parent,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic        found,
  output logic [31:0] out_key,
  output logic [31:0] out_parent,
  output logic [31:0] out_info,
  output logic        last,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);

  plkt_cmd_t  cm;
  plkt_stat_t st;

  plkt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cm       (cm)
  );

  plkt_dpath #(.SLOTS(SLOTS)) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cm           (cm),
    .st           (st),
    .command      (command),
    .key          (key),
    .parent_key   (parent_key),
    .info         (info),
    .check_parent (check_parent),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .found        (found),
    .out_key      (out_key),
    .out_parent   (out_parent),
    .out_info     (out_info),
    .last         (last)
  );

endmodule

>>> hw/rtl/plkt_ctrl.sv
// ----------------------------------------------------------------------------
// plkt_ctrl
// Sequencer that steps the datapath through scans, result emission and the
// delete compaction and orphan-clearing passes.
// ----------------------------------------------------------------------------
module plkt_ctrl import plkt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  plkt_stat_t st,
  output plkt_cmd_t  cm
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_EVAL    = 3'd2;
  localparam logic [2:0] S_DONE    = 3'd3;
  localparam logic [2:0] S_MOVE    = 3'd4;
  localparam logic [2:0] S_MOVE_WR = 3'd5;
  localparam logic [2:0] S_CSCAN   = 3'd6;
  localparam logic [2:0] S_CEVAL   = 3'd7;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cm = '0;
    in_ready = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cm.ld_req = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        state_next = st.scan_end ? S_DONE : S_EVAL;
      end
      S_EVAL: begin
        case (st.cmd)
          CMD_ADD: begin
            cm.upd_flags = 1'b1;
            cm.inc_idx = 1'b1;
            state_next = S_SCAN;
          end
          CMD_LIST: begin
            if (!st.par_hit) begin
              cm.inc_idx = 1'b1;
              state_next = S_SCAN;
            end else if (!st.pend_v || st.out_free) begin
              if (st.pend_v) begin
                cm.out_load = 1'b1;
                cm.out_status = ST_OK;
                cm.out_found = 1'b1;
              end
              cm.cap_hit = 1'b1;
              if (st.nres_max) begin
                state_next = S_DONE;
              end else begin
                cm.inc_idx = 1'b1;
                state_next = S_SCAN;
              end
            end
          end
          default: begin
            if (st.key_hit) begin
              cm.cap_hit = 1'b1;
              state_next = S_DONE;
            end else begin
              cm.inc_idx = 1'b1;
              state_next = S_SCAN;
            end
          end
        endcase
      end
      S_DONE: begin
        if (st.out_free) begin
          cm.out_load = 1'b1;
          cm.out_last = 1'b1;
          state_next = S_IDLE;
          if (st.cmd == CMD_ADD) begin
            cm.out_status = st.add_stat;
            cm.wr_add = (st.add_stat == ST_OK);
          end else begin
            cm.out_status = st.pend_v ? ST_OK : ST_NOTFOUND;
            cm.out_found = st.pend_v;
            if (st.cmd == CMD_DELETE && st.pend_v) begin
              cm.idx_last = 1'b1;
              state_next = S_MOVE;
            end
          end
        end
      end
      S_MOVE: begin
        state_next = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        cm.wr_move = 1'b1;
        cm.cnt_dec = 1'b1;
        cm.clr_idx = 1'b1;
        state_next = S_CSCAN;
      end
      S_CSCAN: begin
        state_next = st.scan_end ? S_IDLE : S_CEVAL;
      end
      S_CEVAL: begin
        cm.wr_clr = st.par_is_key;
        cm.inc_idx = 1'b1;
        state_next = S_CSCAN;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/plkt_dpath.sv
// ----------------------------------------------------------------------------
// plkt_dpath
// Entry memories, scan index, entry count, match flags, pending entry and
// output register of the parent-linked key table.
// ----------------------------------------------------------------------------
module plkt_dpath import plkt_pkg::*; #(
  parameter int SLOTS = DEFAULT_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  plkt_cmd_t   cm,
  output plkt_stat_t  st,
  input  logic [1:0]  command,
  input  logic [31:0] key,
  input  logic [31:0] parent_key,
  input  logic [31:0] info,
  input  logic        check_parent,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic        found,
  output logic [31:0] out_key,
  output logic [31:0] out_parent,
  output logic [31:0] out_info,
  output logic        last
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  logic [31:0] mem_key [SLOTS];
  logic [31:0] mem_par [SLOTS];
  logic [31:0] mem_dat [SLOTS];

  logic [1:0]  req_cmd;
  logic [31:0] req_key, req_par, req_info;
  logic        req_chk;
  logic [6:0]  capacity;
  logic [CW-1:0] idx, count;
  logic [IW-1:0] hidx, waddr;
  logic [31:0] rd_key, rd_par, rd_dat;
  logic [31:0] pend_key, pend_par, pend_dat;
  logic        pend_v, pfound, dup;
  logic [RES_BITS-1:0] nres;
  logic        full;
  logic        out_free;
  logic [31:0] wd_par;

  assign full = (32'(count) >= 32'(capacity)) || (32'(count) >= 32'(SLOTS));
  assign out_free = !out_valid || out_ready;
  assign waddr = cm.wr_add ? count[IW-1:0] : (cm.wr_move ? hidx : idx[IW-1:0]);
  assign wd_par = cm.wr_add ? req_par : (cm.wr_move ? rd_par : 32'd0);

  always_comb begin
    st.cmd = req_cmd;
    st.scan_end = (idx == count);
    st.key_hit = (rd_key == req_key);
    st.par_hit = (rd_par == req_par);
    st.par_is_key = (rd_par == req_key);
    st.pend_v = pend_v;
    st.out_free = out_free;
    st.nres_max = (nres == RES_BITS'(MAX_RESULTS - 1));
    if (full) begin
      st.add_stat = ST_FULL;
    end else if (req_chk && req_par != 32'd0 && !pfound) begin
      st.add_stat = ST_NOPARENT;
    end else if (dup) begin
      st.add_stat = ST_DUP;
    end else begin
      st.add_stat = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cm.wr_add || cm.wr_move) begin
      mem_key[waddr] <= cm.wr_add ? req_key : rd_key;
      mem_dat[waddr] <= cm.wr_add ? req_info : rd_dat;
    end
    if (cm.wr_add || cm.wr_move || cm.wr_clr) begin
      mem_par[waddr] <= wd_par;
    end
    rd_key <= mem_key[idx[IW-1:0]];
    rd_par <= mem_par[idx[IW-1:0]];
    rd_dat <= mem_dat[idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cm.ld_req) begin
      req_cmd <= command;
      req_key <= key;
      req_par <= parent_key;
      req_info <= info;
      req_chk <= check_parent;
    end
    if (cm.cap_hit) begin
      pend_key <= rd_key;
      pend_par <= rd_par;
      pend_dat <= rd_dat;
      hidx <= idx[IW-1:0];
    end
    if (cm.out_load) begin
      status <= cm.out_status;
      found <= cm.out_found;
      last <= cm.out_last;
      out_key <= cm.out_found ? pend_key : 32'd0;
      out_parent <= cm.out_found ? pend_par : 32'd0;
      out_info <= cm.out_found ? pend_dat : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
      count <= '0;
      idx <= '0;
      pend_v <= 1'b0;
      pfound <= 1'b0;
      dup <= 1'b0;
      nres <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (cm.ld_req || cm.clr_idx) begin
        idx <= '0;
      end else if (cm.idx_last) begin
        idx <= count - CW'(1);
      end else if (cm.inc_idx) begin
        idx <= idx + CW'(1);
      end
      if (cm.wr_add) begin
        count <= count + CW'(1);
      end else if (cm.cnt_dec) begin
        count <= count - CW'(1);
      end
      if (cm.ld_req) begin
        pend_v <= 1'b0;
        pfound <= 1'b0;
        dup <= 1'b0;
        nres <= '0;
      end else begin
        if (cm.cap_hit) begin
          pend_v <= 1'b1;
          nres <= nres + RES_BITS'(1);
        end
        if (cm.upd_flags) begin
          pfound <= pfound | (rd_key == req_par);
          dup <= dup | (rd_key == req_key);
        end
      end
      if (cm.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
